// ===== src/ctc_pkg.sv =====
// ctc_pkg: shared types, constants and codes for the charger CAN taper control block
// used by every module in src; depends on nothing
`timescale 1ns / 1ps

package ctc_pkg;

  localparam logic [28:0] StatusId   = 29'h18FF50E5;
  localparam logic [28:0] CommandId  = 29'h1806E5F4;
  localparam logic [4:0]  FaultMask  = 5'h1F;
  localparam int          TaperSpan  = 50;
  localparam int          TaperScale = 256;
  localparam int          TaperGain  = 9;
  localparam int          LowDivisor = 10;
  localparam int          RestartMarginReset = 350;

  // reciprocal constants for the two divisions by a constant
  localparam int          TaperShift = 20;
  localparam int          TaperRecip = TaperScale * ((2**TaperShift + TaperSpan - 1) / TaperSpan);
  localparam int          LowShift   = 19;
  localparam int          LowRecip   = (2**LowShift + LowDivisor - 1) / LowDivisor;

  localparam int          AddrWidth  = 4;

  typedef enum logic [1:0] {
    REG_TARGET_VOLTAGE  = 2'd0,
    REG_FULL_CURRENT    = 2'd1,
    REG_PACK_CHARGE_MAX = 2'd2,
    REG_RESTART_MARGIN  = 2'd3
  } ctc_reg_e;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
    logic        charge_permit;
    logic [15:0] pack_charge_now;
  } ctc_in_t;

  typedef struct packed {
    logic        command_valid;
    logic [15:0] command_voltage;
    logic [15:0] command_current;
    logic        command_stop;
    logic [15:0] measured_voltage;
    logic [15:0] measured_current;
    logic [4:0]  fault_bits;
  } ctc_out_t;

  typedef struct packed {
    logic [15:0] target_voltage;
    logic [15:0] full_current;
    logic [15:0] pack_charge_max;
    logic [15:0] restart_margin;
  } ctc_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic low;
    logic mul;
    logic finish;
  } ctc_cmd_t;

endpackage

// ===== src/ctc_regs.sv =====
// ctc_regs: configuration register file behind the APB-style port
// depends on ctc_pkg
`timescale 1ns / 1ps

module ctc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ctc_pkg::ctc_cfg_t             cfg_o
);
  import ctc_pkg::*;

  ctc_cfg_t cfg_q;
  ctc_reg_e sel;
  logic     wr_en;

  assign sel    = ctc_reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_voltage  <= '0;
      cfg_q.full_current    <= '0;
      cfg_q.pack_charge_max <= '0;
      cfg_q.restart_margin  <= 16'(RestartMarginReset);
    end else if (wr_en) begin
      unique case (sel)
        REG_TARGET_VOLTAGE:  cfg_q.target_voltage  <= pwdata[15:0];
        REG_FULL_CURRENT:    cfg_q.full_current    <= pwdata[15:0];
        REG_PACK_CHARGE_MAX: cfg_q.pack_charge_max <= pwdata[15:0];
        REG_RESTART_MARGIN:  cfg_q.restart_margin  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_TARGET_VOLTAGE:  prdata = {16'd0, cfg_q.target_voltage};
      REG_FULL_CURRENT:    prdata = {16'd0, cfg_q.full_current};
      REG_PACK_CHARGE_MAX: prdata = {16'd0, cfg_q.pack_charge_max};
      REG_RESTART_MARGIN:  prdata = {16'd0, cfg_q.restart_margin};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== src/ctc_ctrl.sv =====
// ctc_ctrl: sequencer for one item through the datapath, plus the output handshake
// depends on ctc_pkg
`timescale 1ns / 1ps

module ctc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ctc_pkg::ctc_cmd_t cmd_o
);
  import ctc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOW,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // output register may be refilled when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.eval   = (state_q == ST_EVAL);
    cmd_o.low    = (state_q == ST_LOW);
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.finish = (state_q == ST_FIN) && out_free;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_EVAL;
        ST_EVAL: state_q <= ST_LOW;
        ST_LOW:  state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_FIN;
        ST_FIN:  if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ctc_datapath.sv =====
// ctc_datapath: charger status state, arming decision, taper arithmetic and result register
// depends on ctc_pkg; steered by ctc_ctrl commands
`timescale 1ns / 1ps

module ctc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctc_pkg::ctc_cmd_t cmd_i,
  input  ctc_pkg::ctc_cfg_t cfg_i,
  input  ctc_pkg::ctc_in_t  in_item_i,
  output ctc_pkg::ctc_out_t out_item_o
);
  import ctc_pkg::*;

  // charger state
  logic [15:0] voltage_seen_q;
  logic [15:0] current_seen_q;
  logic [4:0]  faults_seen_q;
  logic        armed_q;

  // per-item working registers
  logic        status_q;
  logic        ok_q;
  logic [15:0] pack_now_q;
  logic        send_q;
  logic        charge_q;
  logic        taper_q;
  logic [8:0]  t_q;
  logic [12:0] low_q;
  logic [20:0] prod_q;
  ctc_out_t    out_q;

  logic        is_status;
  logic [16:0] restart_sum;
  logic        rearm;
  logic        armed_eff;
  logic signed [16:0] diff;
  logic        disarm;
  logic [28:0] t_full;
  logic [31:0] low_full;
  logic [23:0] prod9;
  logic [15:0] taper_amps;
  logic [15:0] amps;

  assign is_status = (in_item_i.frame_id == StatusId);

  assign restart_sum = {1'b0, voltage_seen_q} + {1'b0, cfg_i.restart_margin};
  assign rearm       = (faults_seen_q == '0) && (restart_sum < {1'b0, cfg_i.target_voltage});
  assign armed_eff   = armed_q | rearm;
  assign diff        = $signed({1'b0, cfg_i.target_voltage}) - $signed({1'b0, voltage_seen_q});
  assign disarm      = (diff <= 17'sd0) || !ok_q;

  // t = diff * 256 / 50 and low = full / 10, both by reciprocal multiply
  assign t_full   = 29'({23'd0, diff[5:0]} * 29'(TaperRecip));
  assign low_full = {16'd0, cfg_i.full_current} * 32'(LowRecip);

  // low * t * 9 as a shift-add on the registered product
  assign prod9      = {prod_q, 3'd0} + {3'd0, prod_q};
  assign taper_amps = 16'({3'd0, low_q} + prod9[23:8]);
  assign amps       = taper_q ? taper_amps : cfg_i.full_current;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voltage_seen_q <= '0;
      current_seen_q <= '0;
      faults_seen_q  <= '0;
      armed_q        <= 1'b1;
    end else begin
      if (cmd_i.load && is_status) begin
        voltage_seen_q <= {in_item_i.data_byte0, in_item_i.data_byte1};
        current_seen_q <= {in_item_i.data_byte2, in_item_i.data_byte3};
        faults_seen_q  <= in_item_i.data_byte4[4:0] & FaultMask;
      end
      if (cmd_i.eval && status_q) begin
        armed_q <= armed_eff & ~disarm;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q   <= is_status;
      ok_q       <= in_item_i.charge_permit;
      pack_now_q <= in_item_i.pack_charge_now;
    end
    if (cmd_i.eval) begin
      send_q   <= status_q & armed_eff;
      charge_q <= (faults_seen_q == '0) && (pack_now_q < cfg_i.pack_charge_max)
                  && armed_eff && !disarm;
      taper_q  <= (diff > 17'sd0) && (diff <= 17'(TaperSpan));
      t_q      <= t_full[28:TaperShift];
    end
    if (cmd_i.low) begin
      low_q <= low_full[LowShift+12:LowShift];
    end
    if (cmd_i.mul) begin
      prod_q <= 21'({8'd0, low_q} * {12'd0, t_q});
    end
    if (cmd_i.finish) begin
      out_q.command_valid    <= send_q;
      out_q.command_voltage  <= send_q ? cfg_i.target_voltage : 16'd0;
      out_q.command_current  <= (send_q && charge_q) ? amps : 16'd0;
      out_q.command_stop     <= send_q & ~charge_q;
      out_q.measured_voltage <= voltage_seen_q;
      out_q.measured_current <= current_seen_q;
      out_q.fault_bits       <= faults_seen_q;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== src/charger_can_taper_control_unit.sv =====
// charger_can_taper_control_unit: top level of the charger CAN taper control block
// depends on ctc_pkg, ctc_regs, ctc_ctrl and ctc_datapath
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid_i / in_stall_o / in_item_i): one received CAN frame per
//   item with the charge permission bit and present pack charge
// - output channel (out_valid_o / out_stall_i / out_item_o): exactly one result item
//   per input item, in order; command_valid marks a command frame to send
// - configuration over the APB-style port, byte address 4*i for register i;
//   writes are expected only while the block is idle
// - the sequencer takes no new item until the last one has passed its load, evaluate,
//   divide-by-ten, taper multiply and finish steps, which share one datapath
// - while a result waits under stall the next item is still taken and worked on;
//   it then holds in the finish step until the output register frees up
// - reset clears the status state, arms the charge request, loads the register
//   defaults (restart margin 350) and empties the output register
module charger_can_taper_control_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ctc_pkg::ctc_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ctc_pkg::ctc_out_t             out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ctc_pkg::*;

  ctc_cfg_t cfg;
  ctc_cmd_t cmd;

  ctc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ctc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ctc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
